FILE: rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared widths, reset values and control types for the lru replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 5;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 32'hFFFF_FFFF;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic en;
        logic insert;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/lru_ref_if.sv
// ----------------------------------------------------------------------------
// lru_ref_if
// page reference channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_ref_if
    import lru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;

    modport source (output valid, output page_number, output last_reference, input ready);
    modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_res_if.sv
// ----------------------------------------------------------------------------
// lru_res_if
// result channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_res_if
    import lru_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] resident_count;
    logic [FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output resident_count, output fault_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input resident_count, input fault_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_cell.sv
// ----------------------------------------------------------------------------
// lru_cell
// one slot of the recency stack: compare, shift from neighbor, tail report
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cell
    import lru_pkg::*;
#(
    parameter int PAGE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cell_ctrl_t           ctrl,
    input  wire logic [PAGE_BITS-1:0] page,
    input  wire logic                 match_in,
    output logic                      match_out,
    input  wire logic [PAGE_BITS-1:0] shift_in,
    output logic [PAGE_BITS-1:0]      entry,
    input  wire logic                 valid_prev,
    input  wire logic                 valid_after,
    output logic                      valid,
    input  wire logic [PAGE_BITS-1:0] tail_in,
    output logic [PAGE_BITS-1:0]      tail_out
);

    logic [PAGE_BITS-1:0] entry_reg;
    logic [PAGE_BITS-1:0] entry_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 own_match;
    logic                 shift;
    logic                 is_tail;

    assign own_match = valid_reg && (entry_reg == page);
    assign match_out = match_in || own_match;

    // shift while no younger slot matched and this slot is in use or being filled
    assign shift = !match_in && (valid_reg || (ctrl.insert && valid_prev));

    assign is_tail  = valid_reg && !valid_after;
    assign tail_out = tail_in | ({PAGE_BITS{is_tail}} & entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.en)
        begin
            if (shift)
            begin
                entry_next = shift_in;
            end
            if (ctrl.clear)
            begin
                valid_next = 1'b0;
            end
            else if (ctrl.insert)
            begin
                valid_next = valid_reg || valid_prev;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page replacement engine built on a chain of compare/shift cells
// ----------------------------------------------------------------------------
// result: registered, offered in the cycle after its reference transfer
// throughput: one reference per cycle; the match and shift ripple through the
//   cell chain in the same cycle, so a stalled result only holds the input
// reset: stack empty, fault count zero, frames_reg at 16; no clearing pass
`default_nettype none

module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    lru_ref_if.sink               refs,
    lru_res_if.source             results
);

    localparam int CNT_W = $clog2(FRAMES + 1);

    // configuration register
    logic [CFG_W-1:0] frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            frames_reg <= cfg_wdata;
        end
    end

    // effective limit: zero acts as one, anything above the frame count is capped
    logic [CNT_W-1:0] limit;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(frames_reg) > FRAMES)
        begin
            limit = CNT_W'(FRAMES);
        end
        else
        begin
            limit = CNT_W'(frames_reg);
        end
    end

    // run state
    logic [CNT_W-1:0]   occupied_reg;
    logic [CNT_W-1:0]   occupied_next;
    logic [FAULT_W-1:0] faults_reg;
    logic [FAULT_W-1:0] faults_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               hit_reg;
    logic               ev_valid_reg;
    logic [PAGE_W-1:0]  ev_page_reg;
    logic [COUNT_W-1:0] resident_reg;
    logic [FAULT_W-1:0] fault_count_reg;

    // reference decode
    logic                 accept;
    logic [31:0]          page_wide;
    logic [PAGE_BITS-1:0] page;
    logic                 hit;
    logic                 has_room;
    logic                 insert;
    logic                 evict;
    logic [CNT_W-1:0]     occupied_after;
    logic [FAULT_W-1:0]   faults_after;
    logic [31:0]          ev_wide;
    cell_ctrl_t           ctrl;

    // next transfer may enter while the current result is being taken
    assign refs.ready = !out_valid_reg || results.ready;
    assign accept     = refs.valid && refs.ready;

    // keep only the low PAGE_BITS of the reference
    assign page_wide = 32'(refs.page_number);
    assign page      = page_wide[PAGE_BITS-1:0];

    // chain wiring: match ripples from the top slot down, tail page ripples up
    logic                 match_chain [0:FRAMES];
    logic [PAGE_BITS-1:0] tail_chain  [0:FRAMES];
    logic [PAGE_BITS-1:0] entries     [0:FRAMES-1];
    logic                 valids      [0:FRAMES-1];

    assign match_chain[0]      = 1'b0;
    assign tail_chain[FRAMES]  = '0;

    genvar k;
    generate
        for (k = 0; k < FRAMES; k++)
        begin : g_cell
            logic [PAGE_BITS-1:0] shift_src;
            logic                 valid_prev;
            logic                 valid_after;

            if (k == 0)
            begin : g_top
                assign shift_src  = page;
                assign valid_prev = 1'b1;
            end
            else
            begin : g_mid
                assign shift_src  = entries[k-1];
                assign valid_prev = valids[k-1];
            end

            if (k == FRAMES - 1)
            begin : g_bottom
                assign valid_after = 1'b0;
            end
            else
            begin : g_inner
                assign valid_after = valids[k+1];
            end

            lru_cell #(
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .page        (page),
                .match_in    (match_chain[k]),
                .match_out   (match_chain[k+1]),
                .shift_in    (shift_src),
                .entry       (entries[k]),
                .valid_prev  (valid_prev),
                .valid_after (valid_after),
                .valid       (valids[k]),
                .tail_in     (tail_chain[k+1]),
                .tail_out    (tail_chain[k])
            );
        end
    endgenerate

    assign hit      = match_chain[FRAMES];
    assign has_room = occupied_reg < limit;
    assign insert   = !hit && has_room;
    // full (or limit lowered below occupancy): bottom slot goes out
    assign evict    = !hit && !has_room;

    assign ctrl.en     = accept;
    assign ctrl.insert = insert;
    assign ctrl.clear  = refs.last_reference;

    assign occupied_after = occupied_reg + CNT_W'(insert);
    assign faults_after   = (!hit && (faults_reg != FAULT_MAX)) ? faults_reg + FAULT_W'(1)
                                                                 : faults_reg;
    assign ev_wide = evict ? 32'(tail_chain[0]) : '0;

    always_comb
    begin
        occupied_next  = occupied_reg;
        faults_next    = faults_reg;
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            // end of run clears after its own result is formed
            if (refs.last_reference)
            begin
                occupied_next = '0;
                faults_next   = '0;
            end
            else
            begin
                occupied_next = occupied_after;
                faults_next   = faults_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg  <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occupied_reg  <= occupied_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on each reference transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg         <= hit;
            ev_valid_reg    <= evict;
            ev_page_reg     <= ev_wide[PAGE_W-1:0];
            resident_reg    <= COUNT_W'(occupied_after);
            fault_count_reg <= faults_after;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.hit            = hit_reg;
    assign results.evicted_valid  = ev_valid_reg;
    assign results.evicted_page   = ev_page_reg;
    assign results.resident_count = resident_reg;
    assign results.fault_count    = fault_count_reg;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru page replacement engine: a recency-stack
// tracker predicts every result, bursty references and a stalling result
// sink exercise the handshakes across several frame limits
// ----------------------------------------------------------------------------

module tb_top;
    import lru_pkg::*;

    localparam int FRAME_SLOTS = 16;     // FRAMES of the instance under test
    localparam int STALL_LIMIT = 2000;   // cycles without any transfer before giving up
    localparam int LONG_HOLD   = 150;    // one long result back-pressure stretch
    localparam int PHASE_REFS  = 190;    // random references per frame setting

    // one expected result, field for field as on the result channel
    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] resident_count;
        logic [FAULT_W-1:0] fault_count;
    } page_outcome_t;

    // recency-stack tracker: own copy of the stack, counters and frame limit
    class lru_tracker;
        logic [PAGE_W-1:0]  stack [FRAME_SLOTS];
        int unsigned        occupied;
        logic [FAULT_W-1:0] faults;
        logic [CFG_W-1:0]   frames;
        page_outcome_t      outstanding [$];
        int                 errors;

        function new();
            foreach (stack[k])
                stack[k] = '0;
            occupied = 0;
            faults   = '0;
            frames   = CFG_RESET;
            errors   = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames = value;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        // entries 0..top-1 move down one slot, page lands on top
        function void shift_in(int top, logic [PAGE_W-1:0] page);
            for (int k = top; k > 0; k--)
                if (k < FRAME_SLOTS)
                    stack[k] = stack[k-1];
            stack[0] = page;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] page, logic last);
            int            limit;
            int            pos;
            page_outcome_t o;
            // zero acts as one frame, anything above the array acts as all of it
            if (frames == 0)
                limit = 1;
            else if (frames > FRAME_SLOTS)
                limit = FRAME_SLOTS;
            else
                limit = frames;
            o   = '0;
            pos = -1;
            for (int k = 0; k < occupied; k++)
                if (pos < 0 && stack[k] == page)
                    pos = k;
            if (pos >= 0)
            begin
                o.hit = 1'b1;
                shift_in(pos, page);
            end
            else
            begin
                if (faults != FAULT_MAX)
                    faults++;
                if (occupied < limit)
                begin
                    shift_in(occupied, page);
                    occupied++;
                end
                else
                begin
                    // stack never shrinks when the limit drops mid-run
                    o.evicted_valid = 1'b1;
                    o.evicted_page  = stack[occupied-1];
                    shift_in(occupied - 1, page);
                end
            end
            o.resident_count = COUNT_W'(occupied);
            o.fault_count    = faults;
            outstanding.push_back(o);
            // end of run: result shows the final state, then everything clears
            if (last)
            begin
                occupied = 0;
                faults   = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_outcome(page_outcome_t got);
            page_outcome_t want;
            if (outstanding.size() == 0)
            begin
                report("result transfer with no reference outstanding");
                return;
            end
            want = outstanding.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit got %0b want %0b", got.hit, want.hit));
            if (got.evicted_valid !== want.evicted_valid)
                report($sformatf("evicted_valid got %0b want %0b",
                                 got.evicted_valid, want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
                report($sformatf("evicted_page got %h want %h",
                                 got.evicted_page, want.evicted_page));
            if (got.resident_count !== want.resident_count)
                report($sformatf("resident_count got %0d want %0d",
                                 got.resident_count, want.resident_count));
            if (got.fault_count !== want.fault_count)
                report($sformatf("fault_count got %0d want %0d",
                                 got.fault_count, want.fault_count));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lru_ref_if refs_ch ();
    lru_res_if res_ch ();

    lru_tracker ledger = new();

    // sender burst bookkeeping
    int burst_left = 1;
    int results_seen = 0;
    int quiet_cycles = 0;

    // page pool for the current run, so that references repeat and hit
    logic [PAGE_W-1:0] pool [24];
    int pool_size = 1;
    int run_left  = 0;

    lru_page_replacement #(
        .FRAMES    (FRAME_SLOTS),
        .PAGE_BITS (PAGE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .refs      (refs_ch),
        .results   (res_ch)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // result side: every result transfer is checked against the oldest
    // expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            ledger.check_outcome('{res_ch.hit, res_ch.evicted_valid, res_ch.evicted_page,
                                   res_ch.resident_count, res_ch.fault_count});
            results_seen++;
        end
    end

    // ready pattern: segments of always ready, mostly ready, mostly stalled
    // and toggling, plus one long hold-off so the block fills and stalls refs
    initial
    begin
        int seg_left;
        int mode;
        bit held;
        seg_left = 0;
        mode     = 0;
        held     = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 400)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default: res_ch.ready <= ~res_ch.ready;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((refs_ch.valid && refs_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, ledger.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all called at a rising edge
    // ------------------------------------------------------------------------

    // offer one reference and hold it until the transfer happens; valid stays
    // high into the next reference unless the burst ends here with a pause
    task automatic send_ref(logic [PAGE_W-1:0] page, logic last);
        int gap;
        refs_ch.valid          <= 1'b1;
        refs_ch.page_number    <= page;
        refs_ch.last_reference <= last;
        @(posedge clk);
        while (!refs_ch.ready)
            @(posedge clk);
        ledger.note_reference(page, last);
        burst_left--;
        if (burst_left <= 0)
        begin
            // short gaps mostly, sometimes a longer pause, sometimes none
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(8, 25);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0)
            begin
                refs_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 20);
        end
    endtask

    // wait until every outstanding result has been taken
    task automatic drain_results();
        refs_ch.valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // frame limit write, only while nothing is in flight
    task automatic write_frames(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        ledger.set_frames(value);
        cfg_we    <= 1'b0;
    endtask

    // random references: mostly drawn from a small per-run pool so hits and
    // evictions both occur, some fully random pages to toggle every bit;
    // runs end at random and may span a change of the frame limit
    task automatic random_refs(int count);
        logic [PAGE_W-1:0] page;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24)
                                                         : $urandom_range(1, 16);
                for (int p = 0; p < pool_size; p++)
                    pool[p] = PAGE_W'($urandom_range(0, 65535));
                run_left = $urandom_range(1, 80);
            end
            if ($urandom_range(0, 99) < 85)
                page = pool[$urandom_range(0, pool_size - 1)];
            else
                page = PAGE_W'($urandom_range(0, 65535));
            run_left--;
            send_ref(page, run_left == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] plan [10];
        plan = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd2, 5'd12, 5'd5};
        plan[8] = CFG_W'($urandom_range(0, 31));

        rst_n                  = 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        refs_ch.valid          <= 1'b0;
        refs_ch.page_number    <= '0;
        refs_ch.last_reference <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit of 16: extreme pages, hits at several depths, end of run on a hit
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hA5A5, 1'b0);
        send_ref(16'h5A5A, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h5A5A, 1'b1);
        drain_results();

        // two frames: fill, evict, hit, evict again; run left open
        write_frames(5'd2);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h0002, 1'b0);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h0002, 1'b0);
        send_ref(16'h0004, 1'b0);
        drain_results();

        // limit of zero acts as one while two pages are resident: stack keeps its size
        write_frames(5'd0);
        send_ref(16'h0002, 1'b0);
        send_ref(16'h0007, 1'b0);
        send_ref(16'h0002, 1'b0);
        send_ref(16'h0009, 1'b1);
        drain_results();

        // limit above the array acts as the full array
        write_frames(5'd31);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h4000, 1'b0);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h4000, 1'b1);
        drain_results();

        // random phases, one frame limit each, lowered and raised along the way
        foreach (plan[p])
        begin
            write_frames(plan[p]);
            random_refs(PHASE_REFS);
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (ledger.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
